// File: design/ray_box_nearest_hit_top_macros.svh
// assertion macros shared by the ray box nearest hit design
`ifndef RAY_BOX_NEAREST_HIT_TOP_MACROS_SVH
`define RAY_BOX_NEAREST_HIT_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBNH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define RBNH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rbnh_pkg.sv
// types and constants of the ray box nearest hit block
`timescale 1ns / 1ps
package rbnh_pkg;

   localparam int TW        = 49;
   localparam int DIV_STEPS = 48;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_DIR_X    = 3'd3;
   localparam logic [2:0] CSR_DIR_Y    = 3'd4;
   localparam logic [2:0] CSR_DIR_Z    = 3'd5;

   localparam logic signed [31:0] ORIGIN_Z_RESET = 32'sd131072;
   localparam logic signed [17:0] DIR_Z_RESET    = -18'sd65536;
   localparam logic signed [31:0] DIST_LIMIT     = 32'sd655360000;
   localparam logic signed [31:0] INT32_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT32_MIN      = 32'sh8000_0000;
   localparam logic signed [TW-1:0] T_MAX32      = 49'sh0_7FFF_FFFF;
   localparam logic signed [TW-1:0] T_MIN32      = -49'sh0_8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_DIV_WAIT,
      ST_EVAL,
      ST_PT_MUL,
      ST_PT_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0] axis;
      logic       bsel;
      logic       load_box;
      logic       zero_check;
      logic       div_start;
      logic       store_t1;
      logic       axis_update;
      logic       eval;
      logic       pt_mul;
      logic       pt_add;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic dir_zero;
      logic div_done;
      logic last;
      logic out_free;
   } sts_type;

endpackage

// File: design/rbnh_div.sv
// iterative restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module rbnh_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rbnh_pkg::DIV_STEPS-1:0] dividend,
   input  logic [17:0]                 divisor,
   input  logic                        negate,
   output logic                        done,
   output logic signed [rbnh_pkg::TW-1:0] quotient
);
   logic [rbnh_pkg::DIV_STEPS-1:0] quo_ff, quo_in;
   logic [17:0] rem_ff, rem_in;
   logic [17:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [18:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, quo_ff[rbnh_pkg::DIV_STEPS-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = negate;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 18'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[rbnh_pkg::DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = trial[17:0];
            quo_in = {quo_ff[rbnh_pkg::DIV_STEPS-2:0], 1'b0};
         end
         cnt_in = 6'(cnt_ff + 6'd1);
         if (cnt_ff == 6'(rbnh_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

// File: design/rbnh_datapath.sv
// datapath: ray registers, box bounds, slab math, running best and result registers
`timescale 1ns / 1ps
module rbnh_datapath #(
   parameter int MAX_BOXES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic signed [31:0]  req_box_min_x,
   input  logic signed [31:0]  req_box_min_y,
   input  logic signed [31:0]  req_box_min_z,
   input  logic signed [31:0]  req_box_max_x,
   input  logic signed [31:0]  req_box_max_y,
   input  logic signed [31:0]  req_box_max_z,
   input  logic                req_last_box,
   input  rbnh_pkg::cmd_type   cmd,
   output rbnh_pkg::sts_type   sts,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_hit,
   output logic [9:0]          rsp_hit_index,
   output logic signed [31:0]  rsp_hit_distance,
   output logic signed [31:0]  rsp_hit_point_x,
   output logic signed [31:0]  rsp_hit_point_y,
   output logic signed [31:0]  rsp_hit_point_z
);
   localparam int CW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int TW = rbnh_pkg::TW;

   logic signed [31:0] origin_ff [3];
   logic signed [17:0] dir_ff [3];
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];
   logic               last_ff;

   logic signed [TW-1:0] t1_ff, near_ff, far_ff;
   logic                 near_inf_ff, far_inf_ff, pass_ff;

   logic signed [31:0] best_ff;
   logic [CW-1:0]      best_idx_ff, cnt_ff;
   logic               found_ff;

   logic signed [49:0] prod_ff;
   logic signed [31:0] pt_ff [3];

   logic               rsp_valid_ff;
   logic               hit_ff;
   logic [9:0]         idx_ff;
   logic signed [31:0] dist_ff, px_ff, py_ff, pz_ff;

   logic signed [31:0] org_sel, bnd_sel;
   logic signed [17:0] dir_sel;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic [17:0]        dir_mag;
   logic               div_done;
   logic signed [TW-1:0] quo, tmn, tmx;
   logic               hit_ok;
   logic signed [31:0] t_sat;
   logic signed [49:0] prod_in;
   logic signed [34:0] sum;
   logic signed [31:0] sum_sat;
   logic [CW+9:0]      idx_ext;
   logic               out_free;

   assign org_sel  = origin_ff[cmd.axis];
   assign dir_sel  = dir_ff[cmd.axis];
   assign bnd_sel  = cmd.bsel ? hi_ff[cmd.axis] : lo_ff[cmd.axis];
   assign diff     = 33'(bnd_sel) - 33'(org_sel);
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   assign dir_mag  = dir_sel[17] ? 18'(-dir_sel) : 18'(dir_sel);

   rbnh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({diff_mag[31:0], 16'd0}),
      .divisor  (dir_mag),
      .negate   (diff[32] ^ dir_sel[17]),
      .done     (div_done),
      .quotient (quo)
   );

   assign tmn = (t1_ff < quo) ? t1_ff : quo;
   assign tmx = (t1_ff < quo) ? quo : t1_ff;

   assign hit_ok = pass_ff && (near_inf_ff || far_inf_ff || !(near_ff > far_ff))
                   && (far_inf_ff || !far_ff[TW-1]);

   always_comb begin
      if (near_inf_ff || near_ff < rbnh_pkg::T_MIN32) t_sat = rbnh_pkg::INT32_MIN;
      else if (near_ff > rbnh_pkg::T_MAX32)           t_sat = rbnh_pkg::INT32_MAX;
      else                                            t_sat = near_ff[31:0];
   end

   assign prod_in = dir_sel * best_ff;
   assign sum     = 35'(org_sel) + 35'(prod_ff >>> 16);

   always_comb begin
      if (sum > 35'sh0_7FFF_FFFF)       sum_sat = rbnh_pkg::INT32_MAX;
      else if (sum < -35'sh0_8000_0000) sum_sat = rbnh_pkg::INT32_MIN;
      else                              sum_sat = sum[31:0];
   end

   assign idx_ext  = {10'd0, best_idx_ff};
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // ray registers
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= rbnh_pkg::ORIGIN_Z_RESET;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= rbnh_pkg::DIR_Z_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            rbnh_pkg::CSR_ORIGIN_X: origin_ff[0] <= csr_data;
            rbnh_pkg::CSR_ORIGIN_Y: origin_ff[1] <= csr_data;
            rbnh_pkg::CSR_ORIGIN_Z: origin_ff[2] <= csr_data;
            rbnh_pkg::CSR_DIR_X:    dir_ff[0]    <= csr_data[17:0];
            rbnh_pkg::CSR_DIR_Y:    dir_ff[1]    <= csr_data[17:0];
            rbnh_pkg::CSR_DIR_Z:    dir_ff[2]    <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // box payload and slab interval
   always_ff @(posedge clock) begin
      if (cmd.load_box) begin
         lo_ff[0] <= req_box_min_x;
         lo_ff[1] <= req_box_min_y;
         lo_ff[2] <= req_box_min_z;
         hi_ff[0] <= req_box_max_x;
         hi_ff[1] <= req_box_max_y;
         hi_ff[2] <= req_box_max_z;
         last_ff  <= req_last_box;
         near_inf_ff <= 1'b1;
         far_inf_ff  <= 1'b1;
         pass_ff     <= 1'b1;
      end
      if (cmd.zero_check) begin
         if (!((org_sel >= lo_ff[cmd.axis] && org_sel <= hi_ff[cmd.axis]) ||
               (org_sel >= hi_ff[cmd.axis] && org_sel <= lo_ff[cmd.axis])))
            pass_ff <= 1'b0;
      end
      if (cmd.store_t1) t1_ff <= quo;
      if (cmd.axis_update) begin
         if (near_inf_ff || tmn > near_ff) begin
            near_ff     <= tmn;
            near_inf_ff <= 1'b0;
         end
         if (far_inf_ff || tmx < far_ff) begin
            far_ff     <= tmx;
            far_inf_ff <= 1'b0;
         end
      end
      if (cmd.pt_mul) prod_ff <= prod_in;
      if (cmd.pt_add) pt_ff[cmd.axis] <= sum_sat;
   end

   // running best over the scan
   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         best_ff     <= rbnh_pkg::DIST_LIMIT;
         best_idx_ff <= '0;
         found_ff    <= 1'b0;
         cnt_ff      <= '0;
      end else if (cmd.eval) begin
         if (hit_ok && t_sat < best_ff) begin
            best_ff     <= t_sat;
            best_idx_ff <= cnt_ff;
            found_ff    <= 1'b1;
         end
         cnt_ff <= (cnt_ff == CW'(MAX_BOXES - 1)) ? '0 : CW'(cnt_ff + 1'b1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.emit)      rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)    rsp_valid_ff <= 1'b0;
      if (cmd.emit) begin
         hit_ff  <= found_ff;
         idx_ff  <= found_ff ? idx_ext[9:0] : 10'd0;
         dist_ff <= found_ff ? best_ff : '0;
         px_ff   <= found_ff ? pt_ff[0] : '0;
         py_ff   <= found_ff ? pt_ff[1] : '0;
         pz_ff   <= found_ff ? pt_ff[2] : '0;
      end
   end

   assign sts.dir_zero = (dir_sel == '0);
   assign sts.div_done = div_done;
   assign sts.last     = last_ff;
   assign sts.out_free = out_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_hit_index    = idx_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_hit_point_x  = px_ff;
   assign rsp_hit_point_y  = py_ff;
   assign rsp_hit_point_z  = pz_ff;
endmodule

// File: design/rbnh_ctrl.sv
// controller state machine: sequences slab divisions, evaluation and result
`timescale 1ns / 1ps
`include "ray_box_nearest_hit_top_macros.svh"
module rbnh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rbnh_pkg::sts_type sts,
   output rbnh_pkg::cmd_type cmd
);
   rbnh_pkg::state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic       bsel_ff, bsel_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      bsel_in  = bsel_ff;
      unique case (state_ff)
         rbnh_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rbnh_pkg::ST_AXIS;
               axis_in  = 2'd0;
               bsel_in  = 1'b0;
            end
         end
         rbnh_pkg::ST_AXIS: begin
            if (sts.dir_zero) begin
               if (axis_ff == 2'd2) state_in = rbnh_pkg::ST_EVAL;
               else axis_in = 2'(axis_ff + 2'd1);
            end else begin
               state_in = rbnh_pkg::ST_DIV_WAIT;
            end
         end
         rbnh_pkg::ST_DIV_WAIT: begin
            if (sts.div_done) begin
               if (!bsel_ff) begin
                  bsel_in  = 1'b1;
                  state_in = rbnh_pkg::ST_AXIS;
               end else begin
                  bsel_in = 1'b0;
                  if (axis_ff == 2'd2) state_in = rbnh_pkg::ST_EVAL;
                  else begin
                     axis_in  = 2'(axis_ff + 2'd1);
                     state_in = rbnh_pkg::ST_AXIS;
                  end
               end
            end
         end
         rbnh_pkg::ST_EVAL: begin
            axis_in  = 2'd0;
            state_in = sts.last ? rbnh_pkg::ST_PT_MUL : rbnh_pkg::ST_IDLE;
         end
         rbnh_pkg::ST_PT_MUL: state_in = rbnh_pkg::ST_PT_ADD;
         rbnh_pkg::ST_PT_ADD: begin
            if (axis_ff == 2'd2) state_in = rbnh_pkg::ST_EMIT;
            else begin
               axis_in  = 2'(axis_ff + 2'd1);
               state_in = rbnh_pkg::ST_PT_MUL;
            end
         end
         rbnh_pkg::ST_EMIT: begin
            if (sts.out_free) state_in = rbnh_pkg::ST_IDLE;
         end
         default: state_in = rbnh_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.axis  = axis_ff;
      cmd.bsel  = bsel_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         rbnh_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_box = req_valid;
         end
         rbnh_pkg::ST_AXIS: begin
            cmd.zero_check = sts.dir_zero && !bsel_ff;
            cmd.div_start  = !sts.dir_zero;
         end
         rbnh_pkg::ST_DIV_WAIT: begin
            cmd.store_t1    = sts.div_done && !bsel_ff;
            cmd.axis_update = sts.div_done && bsel_ff;
         end
         rbnh_pkg::ST_EVAL:   cmd.eval   = 1'b1;
         rbnh_pkg::ST_PT_MUL: cmd.pt_mul = 1'b1;
         rbnh_pkg::ST_PT_ADD: cmd.pt_add = 1'b1;
         rbnh_pkg::ST_EMIT:   cmd.emit   = sts.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbnh_pkg::ST_IDLE;
         axis_ff  <= 2'd0;
         bsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         bsel_ff  <= bsel_in;
      end
   end

   `RBNH_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, sts.out_free, "emit into busy result register")
   `RBNH_ASSERT_NEXT(a_start_wait, clock, reset, cmd.div_start, !sts.div_done && state_ff == rbnh_pkg::ST_DIV_WAIT, "divider start not followed by wait")
   `RBNH_ASSERT_SAME(a_axis_range, clock, reset, cmd.div_start || cmd.zero_check || cmd.pt_add, axis_ff != 2'd3, "axis out of range")
   `RBNH_ASSERT_NEXT(a_eval_once, clock, reset, cmd.eval, !cmd.eval, "box evaluated twice")
endmodule

// File: design/ray_box_nearest_hit_top.sv
// top level of the ray box nearest hit block
`timescale 1ns / 1ps
// nearest axis-aligned box hit along a ray held in csr registers
// csr port: csr_write with csr_index 0..5 selects origin x/y/z then dir x/y/z,
//   csr_data carries the value; write only while the block is idle
// req channel: one box per transaction, req_last_box closes a scan
// rsp channel: one transaction per scan, sent after the box marked last
// per box the slab test runs two divisions per axis with a nonzero direction
//   on one shared bit-serial divider (48 steps); a zero axis needs no division
// after its evaluation, the last box adds three multiply/add pairs for the
//   hit point and the load of the result register
// one box is in flight at a time; req_stall is low only while waiting for a box
// the result register holds the finished transaction while the next scan
//   starts; if the receiver stalls, only the next last box waits for it
// synchronous reset restores the default ray, clears the running best and
//   the box counter, and drops rsp_valid
module ray_box_nearest_hit_top #(
   parameter int MAX_BOXES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   input  logic               req_last_box,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [9:0]         rsp_hit_index,
   output logic signed [31:0] rsp_hit_distance,
   output logic signed [31:0] rsp_hit_point_x,
   output logic signed [31:0] rsp_hit_point_y,
   output logic signed [31:0] rsp_hit_point_z
);
   // command and status between controller and datapath
   rbnh_pkg::cmd_type cmd;
   rbnh_pkg::sts_type sts;

   rbnh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rbnh_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_box_min_x    (req_box_min_x),
      .req_box_min_y    (req_box_min_y),
      .req_box_min_z    (req_box_min_z),
      .req_box_max_x    (req_box_max_x),
      .req_box_max_y    (req_box_max_y),
      .req_box_max_z    (req_box_max_z),
      .req_last_box     (req_last_box),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_hit_index    (rsp_hit_index),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_hit_point_x  (rsp_hit_point_x),
      .rsp_hit_point_y  (rsp_hit_point_y),
      .rsp_hit_point_z  (rsp_hit_point_z)
   );
endmodule

// File: tb/sv/ray_box_nearest_hit_top_test.sv
// self-checking testbench for the ray box nearest hit block
`timescale 1ns / 1ps
module ray_box_nearest_hit_top_test;

   // box transaction as driven on the req channel
   typedef struct {
      logic signed [31:0] mn [3];
      logic signed [31:0] mx [3];
      logic               last;
   } box_type;

   // scan result as seen on the rsp channel
   typedef struct {
      logic               hit;
      logic [9:0]         idx;
      logic signed [31:0] distance;
      logic signed [31:0] pt [3];
   } scan_result_type;

   // directed row: a box, an optional hand-computed answer
   typedef struct {
      box_type         box;
      bit              typed;
      scan_result_type answer;
   } row_type;

   localparam int IDLE_GAP   = 400;
   localparam int WATCH_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_write;
   logic [2:0] csr_index;
   logic [31:0] csr_data;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_box_min_x, req_box_min_y, req_box_min_z;
   logic signed [31:0] req_box_max_x, req_box_max_y, req_box_max_z;
   logic req_last_box;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_hit;
   logic [9:0] rsp_hit_index;
   logic signed [31:0] rsp_hit_distance;
   logic signed [31:0] rsp_hit_point_x, rsp_hit_point_y, rsp_hit_point_z;

   ray_box_nearest_hit_top u_dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z), .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y), .req_box_max_z(req_box_max_z),
      .req_last_box(req_last_box),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_hit_index(rsp_hit_index),
      .rsp_hit_distance(rsp_hit_distance),
      .rsp_hit_point_x(rsp_hit_point_x), .rsp_hit_point_y(rsp_hit_point_y),
      .rsp_hit_point_z(rsp_hit_point_z)
   );

   // predictor copy of the ray registers and the running best
   logic signed [63:0] ray_org [3];
   logic signed [63:0] ray_dir [3];
   logic signed [31:0] near_best;
   logic [9:0]         near_index;
   bit                 near_found;
   logic [9:0]         box_pos;

   scan_result_type expected_scans [$];
   int  mismatch_count;
   int  quiet_cycles;
   int  send_idle_pct;
   int  recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic void clear_running_best();
      near_best  = rbnh_pkg::DIST_LIMIT;
      near_index = '0;
      near_found = 0;
      box_pos    = '0;
   endfunction

   // hit point coordinate: origin + floor(dir * distance / 2^16), saturated
   function automatic logic signed [31:0] point_on_ray(input logic signed [63:0] o,
                                                       input logic signed [63:0] d,
                                                       input logic signed [31:0] t);
      logic signed [63:0] prod;
      prod = d * 64'(t);
      return 32'(clamp32(o + (prod >>> 16)));
   endfunction

   // slab test on one box, update of the running best, result on last
   function automatic bit predict_box(input box_type b, output scan_result_type r);
      logic signed [127:0] tnear, tfar, t1, t2, tmn, tmx, num, lo, hi, a, c;
      bit pass;
      tnear = -(128'sd1 <<< 62);
      tfar  = (128'sd1 <<< 62);
      pass  = 1;
      for (int k = 0; k < 3; k++) begin
         lo = 128'(b.mn[k]);
         hi = 128'(b.mx[k]);
         if (ray_dir[k] == 0) begin
            a = (lo < hi) ? lo : hi;
            c = (lo < hi) ? hi : lo;
            if (!(128'(ray_org[k]) >= a && 128'(ray_org[k]) <= c)) pass = 0;
         end else begin
            // signed division truncates toward zero, as the spec asks
            num = (lo - 128'(ray_org[k])) * 128'sd65536;
            t1  = num / 128'(ray_dir[k]);
            num = (hi - 128'(ray_org[k])) * 128'sd65536;
            t2  = num / 128'(ray_dir[k]);
            tmn = (t1 < t2) ? t1 : t2;
            tmx = (t1 < t2) ? t2 : t1;
            if (tmn > tnear) tnear = tmn;
            if (tmx < tfar) tfar = tmx;
         end
      end
      if (pass && !(tnear > tfar) && !(tfar < 0)) begin
         logic signed [31:0] t;
         t = 32'(clamp32(64'(tnear)));
         if (t < near_best) begin
            near_best  = t;
            near_index = box_pos;
            near_found = 1;
         end
      end
      box_pos = box_pos + 10'd1;
      if (!b.last) return 0;
      r.hit      = near_found;
      r.idx      = near_found ? near_index : '0;
      r.distance = near_found ? near_best : '0;
      for (int k = 0; k < 3; k++)
         r.pt[k] = near_found ? point_on_ray(ray_org[k], ray_dir[k], near_best) : '0;
      clear_running_best();
      return 1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // write one ray register, block idle; the caller drops csr_write
   task automatic write_ray_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      case (idx)
         rbnh_pkg::CSR_ORIGIN_X: ray_org[0] = 64'($signed(val));
         rbnh_pkg::CSR_ORIGIN_Y: ray_org[1] = 64'($signed(val));
         rbnh_pkg::CSR_ORIGIN_Z: ray_org[2] = 64'($signed(val));
         rbnh_pkg::CSR_DIR_X:    ray_dir[0] = 64'($signed(val[17:0]));
         rbnh_pkg::CSR_DIR_Y:    ray_dir[1] = 64'($signed(val[17:0]));
         rbnh_pkg::CSR_DIR_Z:    ray_dir[2] = 64'($signed(val[17:0]));
         default: ;
      endcase
   endtask

   task automatic set_ray(input logic signed [31:0] ox, input logic signed [31:0] oy,
                          input logic signed [31:0] oz, input logic signed [17:0] dx,
                          input logic signed [17:0] dy, input logic signed [17:0] dz);
      write_ray_reg(rbnh_pkg::CSR_ORIGIN_X, ox);
      write_ray_reg(rbnh_pkg::CSR_ORIGIN_Y, oy);
      write_ray_reg(rbnh_pkg::CSR_ORIGIN_Z, oz);
      write_ray_reg(rbnh_pkg::CSR_DIR_X, 32'(dx));
      write_ray_reg(rbnh_pkg::CSR_DIR_Y, 32'(dy));
      write_ray_reg(rbnh_pkg::CSR_DIR_Z, 32'(dz));
      csr_write <= 1'b0;
   endtask

   // drain: every expected scan arrived, then the IDLE_GAP wait
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   // hand one box to the block, optional sender gap first
   task automatic send_box(input box_type b);
      scan_result_type r;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_box_min_x <= b.mn[0];
      req_box_min_y <= b.mn[1];
      req_box_min_z <= b.mn[2];
      req_box_max_x <= b.mx[0];
      req_box_max_y <= b.mx[1];
      req_box_max_z <= b.mx[2];
      req_last_box  <= b.last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      if (predict_box(b, r)) expected_scans.insert(expected_scans.size(), r);
   endtask

   // random coordinate: mostly small, sometimes anywhere
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(9))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return $signed($urandom_range(2000000)) - 32'sd1000000;
      endcase
   endfunction

   function automatic box_type rand_box(input bit last);
      box_type b;
      for (int k = 0; k < 3; k++) begin
         if ($urandom_range(9) < 7) begin
            // box built around a point near the ray so hits are common
            logic signed [31:0] c, h;
            c = 32'(clamp32(ray_org[k] + ray_dir[k] * 64'(int'($urandom_range(40)))
                    + 64'(int'($urandom_range(400000)) - 200000)));
            h = $urandom_range(300000);
            b.mn[k] = 32'(clamp32(64'(c) - h));
            b.mx[k] = 32'(clamp32(64'(c) + h));
            if ($urandom_range(9) == 0) begin
               logic signed [31:0] s;
               s = b.mn[k]; b.mn[k] = b.mx[k]; b.mx[k] = s;
            end
         end else begin
            b.mn[k] = rand_coord();
            b.mx[k] = rand_coord();
         end
      end
      b.last = last;
      return b;
   endfunction

   function automatic logic signed [17:0] rand_dir();
      case ($urandom_range(5))
         0: return 18'sd0;
         1: return $urandom_range(1) ? 18'sd65536 : -18'sd65536;
         2: return 18'($urandom());
         default: return 18'($signed($urandom_range(131072)) - 65536);
      endcase
   endfunction

   // receiver: random stall, compare each scan result against the oldest expected
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scans.size() == 0) begin
               report_mismatch("unexpected result", rsp_hit_distance, 0);
            end else begin
               scan_result_type e;
               e = expected_scans.pop_front();
               if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
               if (rsp_hit_index !== e.idx) report_mismatch("hit_index", rsp_hit_index, e.idx);
               if (rsp_hit_distance !== e.distance)
                  report_mismatch("hit_distance", rsp_hit_distance, e.distance);
               if (rsp_hit_point_x !== e.pt[0])
                  report_mismatch("hit_point_x", rsp_hit_point_x, e.pt[0]);
               if (rsp_hit_point_y !== e.pt[1])
                  report_mismatch("hit_point_y", rsp_hit_point_y, e.pt[1]);
               if (rsp_hit_point_z !== e.pt[2])
                  report_mismatch("hit_point_z", rsp_hit_point_z, e.pt[2]);
            end
         end
         rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog: cycles with no transaction on the req, rsp or csr port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCH_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one box with typed bounds
   function automatic box_type mk(input logic signed [31:0] x0, input logic signed [31:0] y0,
                                  input logic signed [31:0] z0, input logic signed [31:0] x1,
                                  input logic signed [31:0] y1, input logic signed [31:0] z1,
                                  input bit last);
      box_type b;
      b.mn[0] = x0; b.mn[1] = y0; b.mn[2] = z0;
      b.mx[0] = x1; b.mx[1] = y1; b.mx[2] = z1;
      b.last = last;
      return b;
   endfunction

   function automatic scan_result_type res(input bit h, input logic [9:0] i,
                                           input logic signed [31:0] d,
                                           input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz);
      scan_result_type r;
      r.hit = h; r.idx = i; r.distance = d; r.pt[0] = px; r.pt[1] = py; r.pt[2] = pz;
      return r;
   endfunction

   initial begin
      row_type rows [$];
      row_type row;
      scan_result_type r;
      int phase_pct [4][2];
      int scans_left;

      mismatch_count = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = rbnh_pkg::CSR_ORIGIN_X;
      csr_data       = '0;
      req_valid      = 1'b0;
      req_box_min_x  = '0; req_box_min_y = '0; req_box_min_z = '0;
      req_box_max_x  = '0; req_box_max_y = '0; req_box_max_z = '0;
      req_last_box   = 1'b0;
      ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = rbnh_pkg::ORIGIN_Z_RESET;
      ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = rbnh_pkg::DIR_Z_RESET;
      clear_running_best();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the reset ray: origin (0,0,2), looking down -z
      // unit box at z in [0,1]: entry at t = 1.0, hit point (0,0,1)
      row.typed = 1;
      row.box = mk(-65536, -65536, 0, 65536, 65536, 65536, 1);
      row.answer = res(1, 0, 65536, 0, 0, 65536);
      rows.insert(rows.size(), row);
      // no hit at all: everything zero
      row.box = mk(131072, 131072, 0, 196608, 196608, 65536, 1);
      row.answer = res(0, 0, 0, 0, 0, 0);
      rows.insert(rows.size(), row);
      // origin inside the box: negative distance still counts, t = -1.0
      row.box = mk(-65536, -65536, 0, 65536, 65536, 196608, 1);
      row.answer = res(1, 0, -65536, 0, 0, 196608);
      rows.insert(rows.size(), row);
      // swapped bounds, box behind the ray, then nearer box wins at index 2
      row.typed = 0;
      row.box = mk(65536, 65536, 65536, -65536, -65536, 0, 0);
      rows.insert(rows.size(), row);
      row.box = mk(-65536, -65536, 262144, 65536, 65536, 327680, 0);
      rows.insert(rows.size(), row);
      row.box = mk(-65536, -65536, 65536, 65536, 65536, 98304, 0);
      rows.insert(rows.size(), row);
      // tie: later box at the same distance loses
      row.box = mk(-65536, -65536, 65536, 65536, 65536, 98304, 1);
      rows.insert(rows.size(), row);
      // beyond the distance limit: no hit
      row.typed = 1;
      row.box = mk(-65536, -65536, -32'sd700000000, 65536, 65536, -32'sd680000000, 1);
      row.answer = res(0, 0, 0, 0, 0, 0);
      rows.insert(rows.size(), row);
      // full-range box: origin inside, origin on a zero axis boundary
      row.box = mk(32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                   32'sh7FFF_FFFF, 1);
      row.typed = 0;
      rows.insert(rows.size(), row);
      // zero axis with origin outside the bounds: miss
      row.typed = 1;
      row.box = mk(65536, -65536, 0, 131072, 65536, 65536, 1);
      row.answer = res(0, 0, 0, 0, 0, 0);
      rows.insert(rows.size(), row);

      foreach (rows[i]) begin
         send_box(rows[i].box);
         if (rows[i].typed) begin
            r = expected_scans[$];
            if (r.hit !== rows[i].answer.hit || r.distance !== rows[i].answer.distance ||
                r.pt[2] !== rows[i].answer.pt[2])
               report_mismatch("directed row prediction", r.distance,
                               rows[i].answer.distance);
         end
      end
      wait_idle();

      // all-zero direction with origin at the extremes: distance saturates low
      set_ray(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0);
      send_box(mk(32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  0, 1));
      wait_idle();
      // extreme directions and origins, hit points saturate
      set_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 18'sd65536, -18'sd65536,
              18'sd65536);
      send_box(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
      send_box(mk(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1));
      wait_idle();
      set_ray(0, 0, 0, 18'sh1FFFF, 18'sh20000, 18'sd1);
      send_box(mk(32'sh8000_0000, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  2, 1));
      wait_idle();

      // random phases: none, sender idle, receiver stall, both
      phase_pct[0] = '{0, 0};
      phase_pct[1] = '{71, 0};
      phase_pct[2] = '{0, 71};
      phase_pct[3] = '{32, 32};
      for (int p = 0; p < 8; p++) begin
         send_idle_pct  = phase_pct[p % 4][0];
         recv_stall_pct = phase_pct[p % 4][1];
         set_ray(($urandom_range(3) == 0) ? $urandom()
                                          : $signed($urandom_range(400000)) - 200000,
                 ($urandom_range(3) == 0) ? $urandom()
                                          : $signed($urandom_range(400000)) - 200000,
                 ($urandom_range(3) == 0) ? $urandom()
                                          : $signed($urandom_range(400000)) - 200000,
                 rand_dir(), rand_dir(), rand_dir());
         scans_left = 16;
         while (scans_left > 0) begin
            int n;
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1));
            scans_left--;
         end
         wait_idle();
      end

      recv_stall_pct = 0;
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
